[rtl/assert_macros.svh]
// Assertion helpers used by the checker file dfr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DFR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("deframer port assertion failed");

// Check a property on every rising clock edge, reset included.
`define DFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deframer port assertion failed");

`endif

[rtl/dfr_pkg.sv]
package dfr_pkg;

  // Receive store geometry
  localparam int RX_DEPTH = 4096;
  localparam int RX_AW    = $clog2(RX_DEPTH);
  localparam int RX_LW    = $clog2(RX_DEPTH + 1);

  // Output store geometry
  localparam int OUT_DEPTH = 8192;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);

  // Frame format
  localparam logic [7:0]  START_BYTE = 8'h68;
  localparam logic [7:0]  END_BYTE   = 8'h16;
  localparam logic [15:0] MIN_LEN    = 16'd6;
  localparam logic [15:0] MAX_LEN    = 16'd4096;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_TAKE  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
    logic       frames_found;
  } out_item_t;

  // Result handoff from the controller to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

endpackage

[rtl/dfr_ram.sv]
module dfr_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dfr_ctrl.sv]
module dfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dfr_pkg::in_item_t in_data_i,
  output dfr_pkg::res_t     res_o,
  input  logic              res_ready_i
);

  localparam int RAW = dfr_pkg::RX_AW;
  localparam int RLW = dfr_pkg::RX_LW;
  localparam int OAW = dfr_pkg::OUT_AW;
  localparam int OLW = dfr_pkg::OUT_LW;

  typedef enum logic [3:0] {
    S_IDLE, S_TAKE, S_SCAN, S_FIND, S_LEN1, S_LEN2, S_CHKLEN, S_END, S_COPY, S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic            raw_q;
  logic [RAW-1:0]  rx_base_q, rx_base_d;
  logic [RLW-1:0]  rx_level_q, rx_level_d;
  logic [15:0]     len_q, len_d;
  logic            len_ok_q, len_ok_d;
  logic [7:0]      len_lo_q, len_lo_d;
  logic [RAW-1:0]  idx_q, idx_d;
  logic [OAW-1:0]  out_head_q, out_head_d;
  logic [OAW-1:0]  out_tail_q, out_tail_d;
  logic [OLW-1:0]  out_level_q, out_level_d;
  logic            ovf_q, ovf_d, found_q, found_d;
  logic            rvalid_q, rvalid_d, rlast_q, rlast_d;
  logic [7:0]      rbyte_q, rbyte_d;

  logic            rx_we, out_we;
  logic [RAW-1:0]  rx_waddr, rx_raddr;
  logic [7:0]      rx_wdata, rx_rdata;
  logic [OAW-1:0]  out_raddr;
  logic [8:0]      out_wdata, out_rdata;
  logic [15:0]     len_new;
  logic [OLW-1:0]  out_free;
  logic            accept;

  // Receive store: circular, addressed from rx_base_q
  dfr_ram #(.AW(RAW), .DW(8)) u_rx_ram (
    .clk_i, .we_i(rx_we), .waddr_i(rx_waddr), .wdata_i(rx_wdata),
    .raddr_i(rx_raddr), .rdata_o(rx_rdata)
  );

  // Output store: byte plus last mark
  dfr_ram #(.AW(OAW), .DW(9)) u_out_ram (
    .clk_i, .we_i(out_we), .waddr_i(out_tail_q), .wdata_i(out_wdata),
    .raddr_i(out_raddr), .rdata_o(out_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign len_new    = {rx_rdata, len_lo_q};
  assign out_free   = OLW'(dfr_pkg::OUT_DEPTH) - out_level_q;

  // Result presented while waiting for the output register
  always_comb begin
    res_o.valid             = (state_q == S_DONE);
    res_o.item.out_valid    = rvalid_q;
    res_o.item.out_byte     = rbyte_q;
    res_o.item.out_last     = rlast_q;
    res_o.item.overflow     = ovf_q;
    res_o.item.frames_found = found_q;
  end

  // Sequencer: steps through one item at a time; the stores are read every
  // cycle, so a write and a read of the same entry can fall in one cycle.
  always_comb begin
    state_d     = state_q;
    rx_base_d   = rx_base_q;
    rx_level_d  = rx_level_q;
    len_d       = len_q;
    len_ok_d    = len_ok_q;
    len_lo_d    = len_lo_q;
    idx_d       = idx_q;
    out_head_d  = out_head_q;
    out_tail_d  = out_tail_q;
    out_level_d = out_level_q;
    ovf_d       = ovf_q;
    found_d     = found_q;
    rvalid_d    = rvalid_q;
    rlast_d     = rlast_q;
    rbyte_d     = rbyte_q;
    rx_we       = 1'b0;
    rx_waddr    = rx_base_q + rx_level_q[RAW-1:0];
    rx_wdata    = in_data_i.data_byte;
    rx_raddr    = rx_base_q;
    out_we      = 1'b0;
    out_wdata   = {1'b1, in_data_i.data_byte};
    out_raddr   = out_head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ovf_d    = 1'b0;
          found_d  = 1'b0;
          rvalid_d = 1'b0;
          rlast_d  = 1'b0;
          rbyte_d  = 8'd0;
          state_d  = S_DONE;
          case (in_data_i.kind)
            dfr_pkg::KIND_RX: begin
              if (raw_q) begin
                if (out_level_q != OLW'(dfr_pkg::OUT_DEPTH)) begin
                  out_we      = 1'b1;
                  out_tail_d  = out_tail_q + 1'b1;
                  out_level_d = out_level_q + 1'b1;
                  found_d     = 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end else begin
                // Append; a full store drops its oldest byte first
                rx_we = 1'b1;
                if (rx_level_q == RLW'(dfr_pkg::RX_DEPTH)) begin
                  rx_base_d = rx_base_q + 1'b1;
                  len_ok_d  = 1'b0;
                end else begin
                  rx_level_d = rx_level_q + 1'b1;
                end
                state_d = S_SCAN;
              end
            end
            dfr_pkg::KIND_FLUSH: begin
              rx_level_d = '0;
              len_ok_d   = 1'b0;
            end
            dfr_pkg::KIND_TAKE: begin
              if (out_level_q != '0) begin
                out_head_d  = out_head_q + 1'b1;
                out_level_d = out_level_q - 1'b1;
                state_d     = S_TAKE;
              end
            end
            default: ;
          endcase
        end
      end

      S_TAKE: begin
        rvalid_d = 1'b1;
        rbyte_d  = out_rdata[7:0];
        rlast_d  = out_rdata[8];
        state_d  = S_DONE;
      end

      S_SCAN: begin
        if (rx_level_q == '0) begin
          state_d = S_DONE;
        end else if (len_ok_q) begin
          state_d = S_CHKLEN;
        end else begin
          state_d = S_FIND;
        end
      end

      // Drop bytes until a start byte heads the store
      S_FIND: begin
        if (rx_rdata == dfr_pkg::START_BYTE) begin
          if (rx_level_q < RLW'(3)) begin
            state_d = S_DONE;
          end else begin
            rx_raddr = rx_base_q + RAW'(1);
            state_d  = S_LEN1;
          end
        end else begin
          rx_base_d  = rx_base_q + 1'b1;
          rx_level_d = rx_level_q - 1'b1;
          rx_raddr   = rx_base_q + RAW'(1);
          if (rx_level_q == RLW'(1)) begin
            state_d = S_DONE;
          end
        end
      end

      S_LEN1: begin
        len_lo_d = rx_rdata;
        rx_raddr = rx_base_q + RAW'(2);
        state_d  = S_LEN2;
      end

      S_LEN2: begin
        if (len_new < dfr_pkg::MIN_LEN || len_new > dfr_pkg::MAX_LEN ||
            len_new > 16'(dfr_pkg::RX_DEPTH)) begin
          rx_base_d  = rx_base_q + 1'b1;
          rx_level_d = rx_level_q - 1'b1;
          state_d    = S_SCAN;
        end else begin
          len_d    = len_new;
          len_ok_d = 1'b1;
          state_d  = S_CHKLEN;
        end
      end

      S_CHKLEN: begin
        if (16'(rx_level_q) < len_q) begin
          state_d = S_DONE;
        end else begin
          rx_raddr = rx_base_q + len_q[RAW-1:0] - RAW'(1);
          state_d  = S_END;
        end
      end

      S_END: begin
        len_ok_d = 1'b0;
        if (rx_rdata != dfr_pkg::END_BYTE) begin
          rx_base_d  = rx_base_q + 1'b1;
          rx_level_d = rx_level_q - 1'b1;
          state_d    = S_SCAN;
        end else if (16'(out_free) < len_q) begin
          ovf_d      = 1'b1;
          rx_base_d  = rx_base_q + len_q[RAW-1:0];
          rx_level_d = rx_level_q - len_q[RLW-1:0];
          state_d    = S_SCAN;
        end else begin
          found_d  = 1'b1;
          idx_d    = '0;
          rx_raddr = rx_base_q;
          state_d  = S_COPY;
        end
      end

      // Move one byte a cycle: read ahead, write the byte read last cycle
      S_COPY: begin
        out_we      = 1'b1;
        out_wdata   = {(16'(idx_q) + 16'd1 == len_q), rx_rdata};
        out_tail_d  = out_tail_q + 1'b1;
        out_level_d = out_level_q + 1'b1;
        if (16'(idx_q) + 16'd1 == len_q) begin
          rx_base_d  = rx_base_q + len_q[RAW-1:0];
          rx_level_d = rx_level_q - len_q[RLW-1:0];
          state_d    = S_SCAN;
        end else begin
          idx_d    = idx_q + 1'b1;
          rx_raddr = rx_base_q + idx_q + RAW'(1);
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      raw_q       <= 1'b0;
      rx_base_q   <= '0;
      rx_level_q  <= '0;
      len_ok_q    <= 1'b0;
      out_head_q  <= '0;
      out_tail_q  <= '0;
      out_level_q <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        raw_q <= cfg_wdata_i;
      end
      rx_base_q   <= rx_base_d;
      rx_level_q  <= rx_level_d;
      len_ok_q    <= len_ok_d;
      out_head_q  <= out_head_d;
      out_tail_q  <= out_tail_d;
      out_level_q <= out_level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    len_lo_q <= len_lo_d;
    idx_q    <= idx_d;
    ovf_q    <= ovf_d;
    found_q  <= found_d;
    rvalid_q <= rvalid_d;
    rlast_q  <= rlast_d;
    rbyte_q  <= rbyte_d;
  end

endmodule

[rtl/dlt3762_frame_deframer.sv]
// Frame deframer: received bytes gather in a 4096-byte circular receive
// store and are scanned for 0x68 ... 0x16 frames; good frames are copied
// into an 8192-entry output store and read back one byte per take item.
// Each input item gives exactly one result. Items are handled one at a time
// by a sequencer around the two single-port-read memories: a take item reads
// the output store, flush and passthrough items go straight to the result;
// a received byte is appended and the store rescanned: a new header is
// parsed, bytes are dropped one by one while searching for a start byte, and
// a completed frame is copied byte by byte. The result sits in an output
// register, so the next item is taken while it waits.
module dlt3762_frame_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dfr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dfr_pkg::out_item_t out_data_o
);

  dfr_pkg::res_t      res;
  logic               res_ready;
  logic               out_valid_q;
  dfr_pkg::out_item_t out_data_q;

  dfr_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .res_o(res), .res_ready_i(res_ready)
  );

  // Load the output register when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_data_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/dfr_checker.sv]
`include "assert_macros.svh"

module dfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dfr_pkg::out_item_t out_data_o
);

  // A stalled result transfer holds its payload
  `DFR_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // A last mark only comes with a delivered byte
  `DFR_ASSERT(a_last_valid, clk_i, rst_ni, out_valid_o && out_data_o.out_last |-> out_data_o.out_valid)

  // An empty take reads as zero
  `DFR_ASSERT(a_empty_zero, clk_i, rst_ni, out_valid_o && !out_data_o.out_valid |-> out_data_o.out_byte == 8'd0)

  // One item at a time: an input transfer is followed by a stall
  `DFR_ASSERT(a_busy_after, clk_i, rst_ni, in_valid_i && !in_stall_o |=> in_stall_o)

  // Neither overflow nor frames found shares a result with a delivered byte
  `DFR_ASSERT_ALWAYS(a_take_clean, clk_i, !rst_ni || !(out_valid_o && out_data_o.out_valid && (out_data_o.overflow || out_data_o.frames_found)))

endmodule

bind dlt3762_frame_deframer dfr_checker u_dfr_checker (.*);

[test/deframer_checker.sv]
module deframer_checker
  import dfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] rx_bytes[$];
  logic [8:0] out_bytes[$];
  logic       passthru;
  out_item_t  expected_q[$];

  // Remove n bytes from the front of the receive store
  function automatic void rx_discard(int n);
    if (n >= rx_bytes.size()) rx_bytes.delete();
    else if (n > 0) rx_bytes = rx_bytes[n:$];
  endfunction

  // Walk the receive store, queueing every complete frame that fits in the output store
  function automatic void rx_scan(ref logic ovf, ref logic found);
    int s;
    int len;
    while (rx_bytes.size() > 0) begin
      s = 0;
      while (s < rx_bytes.size() && rx_bytes[s] != START_BYTE) s++;
      if (s == rx_bytes.size()) begin
        rx_bytes.delete();
        return;
      end
      rx_discard(s);
      if (rx_bytes.size() < 3) return;
      len = {rx_bytes[2], rx_bytes[1]};
      if (len < MIN_LEN || len > MAX_LEN || len > RX_DEPTH) begin
        rx_discard(1);
        continue;
      end
      if (rx_bytes.size() < len) return;
      if (rx_bytes[len-1] != END_BYTE) begin
        rx_discard(1);
        continue;
      end
      if (OUT_DEPTH - out_bytes.size() < len) ovf = 1'b1;
      else begin
        for (int i = 0; i < len; i++) out_bytes.push_back({i == len - 1, rx_bytes[i]});
        found = 1'b1;
      end
      rx_discard(len);
    end
  endfunction

  // Work out the result one input transfer produces
  function automatic out_item_t deframe_result(in_item_t it);
    out_item_t r;
    logic ovf;
    logic found;
    logic [8:0] e;
    r = '0;
    ovf = 1'b0;
    found = 1'b0;
    case (it.kind)
      KIND_RX: begin
        if (passthru) begin
          if (out_bytes.size() < OUT_DEPTH) begin
            out_bytes.push_back({1'b1, it.data_byte});
            found = 1'b1;
          end else ovf = 1'b1;
        end else begin
          if (rx_bytes.size() >= RX_DEPTH) rx_discard(1);
          rx_bytes.push_back(it.data_byte);
          rx_scan(ovf, found);
        end
      end
      KIND_FLUSH: rx_bytes.delete();
      KIND_TAKE: begin
        if (out_bytes.size() > 0) begin
          e = out_bytes.pop_front();
          r.out_valid = 1'b1;
          r.out_byte = e[7:0];
          r.out_last = e[8];
        end
      end
      default: ;
    endcase
    r.overflow = ovf;
    r.frames_found = found;
    return r;
  endfunction

  function automatic int field_diff(string name, int exp_v, int act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    return 1;
  endfunction

  // Compare output transfers first, then predict from input transfers
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t x;
    int bad;
    if (!rst_ni) begin
      rx_bytes.delete();
      out_bytes.delete();
      expected_q.delete();
      passthru <= 1'b0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_i);
          bad++;
        end else begin
          x = expected_q.pop_front();
          bad += field_diff("out_valid", x.out_valid, out_data_i.out_valid);
          bad += field_diff("out_byte", x.out_byte, out_data_i.out_byte);
          bad += field_diff("out_last", x.out_last, out_data_i.out_last);
          bad += field_diff("overflow", x.overflow, out_data_i.overflow);
          bad += field_diff("frames_found", x.frames_found, out_data_i.frames_found);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(deframe_result(in_data_i));
      if (cfg_we_i) passthru <= cfg_wdata_i;
      fail_count <= fail_count + (bad != 0);
      pending <= expected_q.size();
    end
  end
endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int ITEM_TARGET = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  int        fail_count;
  int        pending;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        sent = 0;
  int        quiet_cycles = 0;

  dlt3762_frame_deframer dut (.*);

  deframer_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count, .pending
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Random receiver stall
  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else if (rst_ni) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic put(input logic [1:0] k, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{kind: k, data_byte: b};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic takes(input int n);
    repeat (n) put(KIND_TAKE, 8'h00);
  endtask

  // Send a frame header with the given length field, a body and an end byte (wrong if bad_end);
  // an oversized length field gets only a short body and no end byte
  task automatic send_frame(input int len, input bit bad_end);
    logic [7:0] tail;
    put(KIND_RX, START_BYTE);
    put(KIND_RX, len[7:0]);
    put(KIND_RX, len[15:8]);
    if (len > int'(MAX_LEN)) begin
      repeat (4) put(KIND_RX, 8'($urandom_range(255)));
      return;
    end
    for (int i = 3; i < len - 1; i++) put(KIND_RX, 8'($urandom_range(255)));
    tail = END_BYTE;
    if (bad_end) while (tail == END_BYTE) tail = 8'($urandom_range(255));
    if (len > 3) put(KIND_RX, tail);
  endtask

  task automatic set_phase(input int p);
    case (p % 4)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 52; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 52; end
      default: begin idle_pct = 11; stall_pct = 11; end
    endcase
  endtask

  initial begin
    int r;
    int len;
    int phase;
    int next_switch;
    logic [7:0] two_frames[16];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty take, unused kind, flush, extreme bytes, short frame
    put(KIND_TAKE, 8'hff);
    put(KIND_UNUSED, 8'hff);
    put(KIND_FLUSH, 8'h00);
    put(KIND_RX, 8'h00);
    put(KIND_RX, 8'hff);
    put(KIND_RX, START_BYTE);
    put(KIND_RX, 8'h06);
    put(KIND_RX, 8'h00);
    put(KIND_RX, 8'h00);
    put(KIND_RX, 8'hff);
    put(KIND_RX, END_BYTE);
    takes(7);
    // Length limits below and above, then a flush mid frame
    send_frame(5, 0);
    send_frame(4097, 0);
    send_frame(16'hffff, 0);
    put(KIND_RX, START_BYTE);
    put(KIND_FLUSH, 8'h00);
    // Bad outer frame whose rescan releases two inner frames at once
    two_frames = '{8'h68, 8'h10, 8'h00, 8'h68, 8'h06, 8'h00, 8'h01, 8'h02,
                   8'h16, 8'h68, 8'h06, 8'h00, 8'h03, 8'h04, 8'h16, 8'h55};
    foreach (two_frames[i]) put(KIND_RX, two_frames[i]);
    takes(13);
    // Long frame
    send_frame(300, 0);
    takes(300);

    // Passthrough bytes, then back to deframing
    set_mode(1'b1);
    for (int i = 0; i < 20; i++) put(KIND_RX, i[7:0]);
    set_mode(1'b0);
    send_frame(6, 0);
    takes(30);

    // Random part in phases of idling, stalling and mode
    phase = 0;
    next_switch = sent;
    while (sent < ITEM_TARGET) begin
      if (sent >= next_switch) begin
        next_switch = sent + 200;
        phase++;
        set_mode(phase % 5 == 3);
        set_phase(phase);
      end
      r = $urandom_range(99);
      if (r < 55) begin
        len = ($urandom_range(49) == 0) ? $urandom_range(41, 300) : $urandom_range(6, 40);
        send_frame(len, 0);
        takes($urandom_range(len + 4));
      end else if (r < 63) begin
        len = $urandom_range(1) ? $urandom_range(5) : $urandom_range(4097, 65535);
        send_frame(len, 0);
        repeat ($urandom_range(1, 6)) put(KIND_RX, 8'($urandom_range(255)));
      end else if (r < 71) begin
        send_frame($urandom_range(6, 30), 1);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 8)) put(KIND_RX, 8'($urandom_range(255)));
      end else if (r < 81) begin
        put(KIND_FLUSH, 8'($urandom_range(255)));
      end else if (r < 83) begin
        put(KIND_UNUSED, 8'($urandom_range(255)));
      end else begin
        takes($urandom_range(1, 20));
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
